### sv/fir_pkg.sv
// Shared widths and constants for the circular-buffer FIR filter.
package fir_pkg;

  localparam int NUM_COEFS   = 8;
  localparam int COEF_IDX_W  = 3;
  localparam int CFG_IDX_W   = 4;
  localparam int COEF_W      = 16;
  localparam int RAW_W       = 14;
  localparam int SAMPLE_DROP = 5;
  localparam int SAMPLE_W    = RAW_W - SAMPLE_DROP;
  localparam int DUTY_W      = 9;
  localparam int FRAC_W      = 15;
  localparam int PROD_W      = SAMPLE_W + 1 + COEF_W;
  localparam int ACC_W       = PROD_W + COEF_IDX_W;
  localparam int QUOT_W      = ACC_W - FRAC_W;

  localparam logic [DUTY_W-1:0] DUTY_MAX = {DUTY_W{1'b1}};

  typedef logic [SAMPLE_W-1:0]      sample_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

endpackage

### sv/fir_if.sv
// Valid/ready channel interfaces for the FIR filter sample input and duty output.
interface fir_in_if import fir_pkg::*;;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface fir_out_if import fir_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty;

  modport source (output valid, output duty, input ready);
  modport sink   (input valid, input duty, output ready);
endinterface

### sv/fir_filter_circular.sv
// Direct-form FIR filter, circular delay line, one shared multiply-accumulate.
//
//  channel   dir  transfer when        payload
//  in_ch     in   valid && ready       raw_sample[13:0]
//  out_ch    out  valid && ready       duty[8:0]
//  cfg_*     in   cfg_we               cfg_index[3:0], cfg_wdata[15:0]
//
// Each sample steps through accept, TAPS multiplies through the single
// multiplier, one accumulate drain, one clamp/load of the output register.
// in_ch.ready is high only while the sequencer is idle.
// A finished result waits in the output register; the next sample may be
// accepted meanwhile, and the sequencer holds its result until that slot frees.
// rst_n (sync, low) clears coefficients, delay line, pointer and control.
module fir_filter_circular import fir_pkg::*; #(
  parameter int TAPS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  fir_in_if.sink               in_ch,
  fir_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_wdata
);

  localparam int PTR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [PTR_W-1:0]      LAST_PTR = PTR_W'(TAPS - 1);
  localparam logic [COEF_IDX_W-1:0] LAST_TAP = COEF_IDX_W'(TAPS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAC   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  coef_t                 coef_r [NUM_COEFS];
  sample_t               line_r [TAPS];
  logic [PTR_W-1:0]      wp_r, wp_nxt;
  logic [PTR_W-1:0]      idx_r, idx_nxt;
  logic [COEF_IDX_W-1:0] k_r, k_nxt;
  prod_t                 prod_r;
  logic                  prod_vld_r, prod_vld_nxt;
  acc_t                  acc_r, acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0]     duty_r;
  logic [DUTY_W-1:0]     duty_nxt;
  logic [QUOT_W-1:0]     quot;
  prod_t                 prod_nxt;
  logic                  in_xfer;
  logic                  out_free;
  sample_t               new_sample;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.duty  = duty_r;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign new_sample   = in_ch.raw_sample[RAW_W-1:SAMPLE_DROP];

  assign prod_nxt = $signed({1'b0, line_r[idx_r]}) * coef_r[k_r];

  assign quot = acc_r[ACC_W-1:FRAC_W];
  always_comb begin
    if (acc_r <= 0) begin
      duty_nxt = '0;
    end else if (quot > QUOT_W'(DUTY_MAX)) begin
      duty_nxt = DUTY_MAX;
    end else begin
      duty_nxt = quot[DUTY_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    prod_vld_nxt  = 1'b0;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          idx_nxt   = wp_r;
          k_nxt     = '0;
          acc_nxt   = '0;
          wp_nxt    = (wp_r == LAST_PTR) ? '0 : wp_r + PTR_W'(1);
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        prod_vld_nxt = 1'b1;
        if (prod_vld_r) begin
          acc_nxt = acc_r + ACC_W'(prod_r);
        end
        idx_nxt = (idx_r == '0) ? LAST_PTR : idx_r - PTR_W'(1);
        k_nxt   = k_r + COEF_IDX_W'(1);
        if (k_r == LAST_TAP) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        acc_nxt   = acc_r + ACC_W'(prod_r);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      idx_r       <= '0;
      k_r         <= '0;
      prod_vld_r  <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      prod_vld_r  <= prod_vld_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (state_r == S_DONE && out_free) begin
      duty_r <= duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_COEFS))) begin
      coef_r[cfg_index[COEF_IDX_W-1:0]] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        line_r[i] <= '0;
      end
    end else if (in_xfer) begin
      line_r[wp_r] <= new_sample;
    end
  end

  a_start_mac: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_MAC) && (k_r == '0))
    else $error("sequencer did not start at tap 0");

  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= LAST_PTR)
    else $error("write pointer out of range");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_PTR)
    else $error("read index out of range");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result shown without finishing");

  a_flush_has_prod: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) |-> prod_vld_r)
    else $error("last product missing at flush");

endmodule

### bench/tb.sv
// Self-checking testbench for the circular-buffer FIR filter with clamped duty output.
`timescale 1ns / 1ps

module tb;
  import fir_pkg::*;

  localparam int TAPS            = 8;
  localparam int RAW_MAX         = (1 << RAW_W) - 1;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_SAMPLES   = 75;
  localparam int CALM_SAMPLES    = 50;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0] cfg_wdata;

  fir_in_if  in_if ();
  fir_out_if out_if ();

  fir_filter_circular #(.TAPS(TAPS)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if.sink),
    .out_ch   (out_if.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // filter state mirror
  coef_t coefs [NUM_COEFS];
  coef_t coef_plan [NUM_COEFS];
  sample_t taps_line [TAPS];
  int unsigned wr_slot;

  logic [DUTY_W-1:0] duty_expected [$];
  int errors;
  int n_samples;
  int n_duty;
  int n_cfg_sets;
  int idle_cycles;
  bit src_idle_en;
  bit snk_idle_en;
  int snk_stall;

  function automatic logic [DUTY_W-1:0] filter_step(input logic [RAW_W-1:0] raw);
    int unsigned slot;
    longint acc;
    longint q;
    taps_line[wr_slot] = raw[RAW_W-1:SAMPLE_DROP];
    slot = wr_slot;
    acc = 0;
    for (int k = 0; k < TAPS; k++) begin
      acc += longint'(taps_line[slot]) * longint'(coefs[k]);
      slot = (slot == 0) ? TAPS - 1 : slot - 1;
    end
    wr_slot = (wr_slot + 1 >= TAPS) ? 0 : wr_slot + 1;
    if (acc <= 0) return '0;
    q = acc >>> FRAC_W;
    if (q > longint'(DUTY_MAX)) return DUTY_MAX;
    return q[DUTY_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("ERROR @%0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  // result sink stalls
  always @(negedge clk) begin
    if (snk_stall > 0) begin
      out_if.ready = 1'b0;
      snk_stall--;
    end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
      out_if.ready = 1'b0;
      snk_stall = $urandom_range(1, 5) - 1;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  // duty checker and watchdog
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (out_if.valid && out_if.ready) begin
        n_duty++;
        if (duty_expected.size() == 0)
          report_mismatch("unexpected duty transfer, pending", 0, int'(out_if.duty));
        else if (out_if.duty !== duty_expected[0]) begin
          report_mismatch("duty", int'(duty_expected[0]), int'(out_if.duty));
          void'(duty_expected.pop_front());
        end else
          void'(duty_expected.pop_front());
      end
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_CYCLES);
        $display("fir_filter_circular regression: fail");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [RAW_W-1:0] raw);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.raw_sample = raw;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    duty_expected.push_back(filter_step(raw));
    n_samples++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (duty_expected.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [COEF_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = CFG_IDX_W'(idx);
    cfg_wdata = data;
    if (idx < NUM_COEFS) coefs[idx] = coef_t'(data);
    @(negedge clk);
  endtask

  task automatic program_coefs();
    wait_drained();
    for (int k = 0; k < NUM_COEFS; k++) write_reg(k, coef_plan[k]);
    cfg_we = 1'b0;
    n_cfg_sets++;
  endtask

  task automatic plan_single(input int tap, input coef_t val);
    foreach (coef_plan[k]) coef_plan[k] = '0;
    coef_plan[tap] = val;
  endtask

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return RAW_W'(RAW_MAX);
      2: return RAW_W'($urandom_range(0, (1 << SAMPLE_DROP) - 1));
      default: return RAW_W'($urandom_range(0, RAW_MAX));
    endcase
  endfunction

  function automatic coef_t pick_coef(input bit gentle);
    if (gentle) return coef_t'($urandom_range(0, 8192) - 4096);
    case ($urandom_range(0, 7))
      0: return coef_t'(16'h8000);
      1: return coef_t'(16'h7FFF);
      2: return '0;
      default: return coef_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic test_reset_state();
    send_sample(RAW_W'(RAW_MAX));
    send_sample(RAW_W'(RAW_MAX));
    send_sample('0);
    send_sample(RAW_W'(14'h2AAA));
  endtask

  task automatic test_passthrough();
    plan_single(0, coef_t'(16'h7FFF));
    program_coefs();
    send_sample('0);
    send_sample(RAW_W'(RAW_MAX));
    send_sample(RAW_W'(31));
    send_sample(RAW_W'(32));
    send_sample(RAW_W'(14'h2AA0));
    send_sample(RAW_W'(14'h1540));
  endtask

  task automatic test_saturation();
    foreach (coef_plan[k]) coef_plan[k] = coef_t'(16'h7FFF);
    program_coefs();
    repeat (4) send_sample(RAW_W'(RAW_MAX));
  endtask

  task automatic test_negative_sum();
    foreach (coef_plan[k]) coef_plan[k] = coef_t'(16'h8000);
    program_coefs();
    send_sample(RAW_W'(RAW_MAX));
    send_sample(RAW_W'(14'h2000));
    // large negative newest tap against positive history
    foreach (coef_plan[k]) coef_plan[k] = coef_t'(16'h2000);
    coef_plan[0] = coef_t'(16'h8000);
    program_coefs();
    send_sample(RAW_W'(RAW_MAX));
    send_sample(RAW_W'(14'h0400));
  endtask

  task automatic test_tap_order();
    // only the oldest tap contributes
    plan_single(TAPS - 1, coef_t'(16'h7FFF));
    program_coefs();
    send_sample(RAW_W'(14'h3000));
    send_sample(RAW_W'(14'h0100));
    send_sample(RAW_W'(14'h1F00));
  endtask

  task automatic test_unused_index();
    plan_single(3, coef_t'(16'h4000));
    program_coefs();
    for (int idx = NUM_COEFS; idx < (1 << CFG_IDX_W); idx++)
      write_reg(idx, 16'hFFFF);
    cfg_we = 1'b0;
    send_sample(RAW_W'(RAW_MAX));
    send_sample(RAW_W'(14'h1234));
    send_sample(RAW_W'(14'h3FE0));
  endtask

  task automatic test_random();
    bit gentle;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gentle = (p % 2 == 1);
      foreach (coef_plan[k]) coef_plan[k] = pick_coef(gentle);
      program_coefs();
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(NUM_COEFS, (1 << CFG_IDX_W) - 1), 16'($urandom));
        cfg_we = 1'b0;
      end
      repeat (PHASE_SAMPLES) send_sample(pick_raw());
    end
  endtask

  task automatic test_back_to_back();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    foreach (coef_plan[k]) coef_plan[k] = pick_coef(1'b1);
    program_coefs();
    repeat (CALM_SAMPLES) send_sample(pick_raw());
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.raw_sample = '0;
    out_if.ready = 1'b1;
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    snk_stall = 0;
    errors = 0;
    n_samples = 0;
    n_duty = 0;
    n_cfg_sets = 0;
    idle_cycles = 0;
    wr_slot = 0;
    foreach (coefs[k]) coefs[k] = '0;
    foreach (taps_line[k]) taps_line[k] = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_passthrough();
    test_saturation();
    test_negative_sum();
    test_tap_order();
    test_unused_index();
    test_random();
    test_back_to_back();

    wait_drained();
    repeat (TAPS + 8) @(negedge clk);
    if (duty_expected.size() != 0)
      report_mismatch("duty results never delivered, count", 0, duty_expected.size());

    $display("covered %0d samples, %0d duty transfers, %0d coefficient sets",
             n_samples, n_duty, n_cfg_sets);
    $display("clamp at both ends, tap order, ignored register indexes, random stalls");
    if (errors == 0)
      $display("fir_filter_circular regression: pass");
    else
      $display("fir_filter_circular regression: fail");
    $finish;
  end

endmodule

### files.f
sv/fir_pkg.sv
sv/fir_if.sv
sv/fir_filter_circular.sv
bench/tb.sv
